[src/mssc_pkg.sv]
// Package for the motor speed step controller: field widths, arithmetic constants
// and the band table that seeds the drive level on a target change.
// No dependencies.
package mssc_pkg;

  localparam int TargetW = 16;
  localparam int EncW    = 32;
  localparam int TimeW   = 32;
  localparam int DriveW  = 9;
  localparam int RpmW    = 8;
  localparam int AngleW  = 10;
  localparam int InDataW  = 80;
  localparam int OutDataW = 24;

  // Magnitude of encoder_count / 2 needs 31 bits, and the angle remainder stays below 360.
  localparam int ModBits    = EncW - 1;
  localparam int RemW       = 9;
  localparam int AngleMod   = 360;
  // The speed dividend is |delta angle| * 1000, at most 718000.
  localparam int NumW       = 20;
  localparam int DenW       = TimeW + 3;
  localparam int MsScale    = 1000;
  localparam int EstLimit   = 80;
  localparam int DriveWrap  = 256;
  localparam int BandMax    = 70;
  localparam int BandStep   = 10;
  localparam int BandCount  = 7;

  typedef logic signed [DriveW-1:0] drive_t;

  localparam drive_t POS_SEED [BandCount] = '{
    9'sd30, 9'sd45, 9'sd55, 9'sd67, 9'sd82, 9'sd110, 9'sd180
  };
  localparam drive_t NEG_SEED [BandCount] = '{
    -9'sd30, -9'sd45, -9'sd57, -9'sd67, -9'sd82, -9'sd110, -9'sd145
  };

  // Nonzero targets within 70 RPM of zero pick a seed by 10 RPM band; all others keep the drive.
  function automatic drive_t band_seed(logic signed [TargetW-1:0] t, drive_t keep);
    logic signed [TargetW:0] mag;
    logic [2:0]              idx;
    drive_t                  res;
    mag = t[TargetW-1] ? -(TargetW+1)'(t) : (TargetW+1)'(t);
    idx = '0;
    for (int k = 1; k < BandCount; k++) begin
      if (mag > (TargetW+1)'(k * BandStep)) begin
        idx = 3'(k);
      end
    end
    res = keep;
    if (t != '0 && mag <= (TargetW+1)'(BandMax)) begin
      res = t[TargetW-1] ? NEG_SEED[idx] : POS_SEED[idx];
    end
    return res;
  endfunction

endpackage

[src/motor_speed_step_controller.sv]
// Top level of the motor speed step controller: stream ports, bit-serial modulo-360
// reduction, bit-serial restoring speed divider and the drive update.
// Depends on mssc_pkg.

// One transaction in gives one transaction out. When the angle changed over a nonzero
// elapsed time, an item passes through reducing the halved encoder count modulo 360 one
// bit per cycle, forming the speed dividend and divisor, the one-bit-per-cycle restoring
// divider and the drive update. Otherwise the divider is skipped. The drive update waits
// while an earlier result in the output register has not been taken, and the input is
// ready again in the cycle after the drive update. A new item is taken once the previous
// one has reached the output register, even while that result still waits for tready.
module motor_speed_step_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // target_rpm [15:0], encoder_count [47:16], time_ms [79:48]
  input  logic [mssc_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // drive [8:0], measured_rpm [16:9], zero [23:17]
  output logic [mssc_pkg::OutDataW-1:0] m_axis_tdata_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_PREP   = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [4:0]                            cnt_q, cnt_d;
  logic signed [mssc_pkg::TargetW-1:0]   tgt_q;
  logic [mssc_pkg::TimeW-1:0]            now_q;
  logic                                  encneg_q;
  logic [mssc_pkg::ModBits-1:0]          shr_q;
  logic [mssc_pkg::RemW-1:0]             rem_q;
  logic signed [mssc_pkg::AngleW-1:0]    angle_q;
  logic                                  changed_q;
  logic                                  div_q;
  logic                                  qneg_q;
  logic [mssc_pkg::NumW-1:0]             dvd_q;
  logic [mssc_pkg::DenW-1:0]             den_q;
  logic [mssc_pkg::DenW-1:0]             prem_q;

  logic signed [mssc_pkg::TargetW-1:0]   prev_target_q;
  mssc_pkg::drive_t                      drive_q;
  logic signed [mssc_pkg::AngleW-1:0]    prev_angle_q;
  logic [mssc_pkg::TimeW-1:0]            prev_time_q;
  logic signed [mssc_pkg::RpmW-1:0]      speed_q;

  logic                                  m_tvalid_q;
  logic [mssc_pkg::OutDataW-1:0]         m_tdata_q;

  logic                                  in_fire;
  logic                                  commit;
  logic                                  red_last;
  logic                                  div_last;

  // Input field split and encoder magnitude.
  logic signed [mssc_pkg::TargetW-1:0]   in_target;
  logic signed [mssc_pkg::EncW-1:0]      in_enc;
  logic [mssc_pkg::TimeW-1:0]            in_time;
  logic [mssc_pkg::EncW-1:0]             enc_abs;

  assign in_target = s_axis_tdata_i[15:0];
  assign in_enc    = s_axis_tdata_i[47:16];
  assign in_time   = s_axis_tdata_i[79:48];
  assign enc_abs   = in_enc[mssc_pkg::EncW-1] ? -in_enc : in_enc;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign commit          = (state_q == ST_FINISH) && (!m_tvalid_q || m_axis_tready_i);
  assign red_last        = (cnt_q == 5'(mssc_pkg::ModBits - 1));
  assign div_last        = (cnt_q == 5'(mssc_pkg::NumW - 1));

  // One step of the modulo-360 reduction, most significant bit first.
  logic [mssc_pkg::RemW:0] red_t;
  logic [mssc_pkg::RemW:0] red_r;
  always_comb begin
    red_t = {rem_q, shr_q[mssc_pkg::ModBits-1]};
    red_r = (red_t >= (mssc_pkg::RemW+1)'(mssc_pkg::AngleMod))
          ? red_t - (mssc_pkg::RemW+1)'(mssc_pkg::AngleMod) : red_t;
  end

  // Angle, delta and the divider operands.
  logic signed [mssc_pkg::AngleW-1:0]    angle_c;
  logic signed [mssc_pkg::AngleW:0]      delta_c;
  logic [mssc_pkg::AngleW-1:0]           dmag_c;
  logic [mssc_pkg::TimeW-1:0]            elapsed_c;
  logic [mssc_pkg::DenW-1:0]             den_c;
  logic [mssc_pkg::NumW-1:0]             num_c;
  always_comb begin
    angle_c   = encneg_q ? -mssc_pkg::AngleW'(rem_q) : mssc_pkg::AngleW'(rem_q);
    delta_c   = (mssc_pkg::AngleW+1)'(angle_c) - (mssc_pkg::AngleW+1)'(prev_angle_q);
    dmag_c    = delta_c[mssc_pkg::AngleW] ? mssc_pkg::AngleW'(-delta_c)
                                          : mssc_pkg::AngleW'(delta_c);
    num_c     = mssc_pkg::NumW'(dmag_c) * mssc_pkg::NumW'(mssc_pkg::MsScale);
    elapsed_c = now_q - prev_time_q;
    // elapsed * 6 as (elapsed << 2) + (elapsed << 1).
    den_c     = (mssc_pkg::DenW'(elapsed_c) << 2) + (mssc_pkg::DenW'(elapsed_c) << 1);
  end

  // One restoring division step.
  logic [mssc_pkg::DenW:0] div_t;
  logic                    div_ge;
  always_comb begin
    div_t  = {prem_q, dvd_q[mssc_pkg::NumW-1]};
    div_ge = (div_t >= {1'b0, den_q});
  end

  // Speed acceptance and drive update.
  logic signed [mssc_pkg::RpmW-1:0]      est_c;
  mssc_pkg::drive_t                      seed_c;
  logic signed [mssc_pkg::DriveW:0]      step_c;
  mssc_pkg::drive_t                      drive_c;
  always_comb begin
    est_c = speed_q;
    if (div_q && dvd_q < mssc_pkg::NumW'(mssc_pkg::EstLimit)) begin
      est_c = qneg_q ? -mssc_pkg::RpmW'(dvd_q) : mssc_pkg::RpmW'(dvd_q);
    end
    seed_c = (tgt_q != prev_target_q) ? mssc_pkg::band_seed(tgt_q, drive_q) : drive_q;
    step_c = (mssc_pkg::DriveW+1)'(seed_c);
    if (mssc_pkg::TargetW'(est_c) < tgt_q) begin
      step_c = (mssc_pkg::DriveW+1)'(seed_c) + (mssc_pkg::DriveW+1)'(1);
    end
    if (mssc_pkg::TargetW'(est_c) > tgt_q) begin
      step_c = (mssc_pkg::DriveW+1)'(seed_c) - (mssc_pkg::DriveW+1)'(1);
    end
    // Truncating modulo 256 only ever folds the two extreme values; a zero target clears the drive.
    if (step_c == (mssc_pkg::DriveW+1)'(mssc_pkg::DriveWrap) ||
        step_c == -(mssc_pkg::DriveW+1)'(mssc_pkg::DriveWrap) || tgt_q == '0) begin
      drive_c = '0;
    end else begin
      drive_c = mssc_pkg::DriveW'(step_c);
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 5'd1;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_fire) begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (red_last) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cnt_d = '0;
        if (angle_c != prev_angle_q && elapsed_c != '0) begin
          state_d = ST_DIVIDE;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        if (div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      prev_target_q <= '0;
      drive_q       <= '0;
      prev_angle_q  <= '0;
      prev_time_q   <= '0;
      speed_q       <= '0;
      m_tvalid_q    <= 1'b0;
      div_q         <= 1'b0;
      changed_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == ST_PREP) begin
        changed_q <= (angle_c != prev_angle_q);
        div_q     <= (angle_c != prev_angle_q) && (elapsed_c != '0);
      end
      if (commit) begin
        prev_target_q <= tgt_q;
        drive_q       <= drive_c;
        speed_q       <= est_c;
        if (changed_q) begin
          prev_angle_q <= angle_q;
          prev_time_q  <= now_q;
        end
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          tgt_q    <= in_target;
          now_q    <= in_time;
          encneg_q <= in_enc[mssc_pkg::EncW-1];
          shr_q    <= enc_abs[mssc_pkg::EncW-1:1];
          rem_q    <= '0;
        end
      end
      ST_REDUCE: begin
        rem_q <= red_r[mssc_pkg::RemW-1:0];
        shr_q <= {shr_q[mssc_pkg::ModBits-2:0], 1'b0};
      end
      ST_PREP: begin
        angle_q <= angle_c;
        qneg_q  <= delta_c[mssc_pkg::AngleW];
        dvd_q   <= num_c;
        den_q   <= den_c;
        prem_q  <= '0;
      end
      ST_DIVIDE: begin
        prem_q <= div_ge ? mssc_pkg::DenW'(div_t - {1'b0, den_q})
                         : mssc_pkg::DenW'(div_t);
        dvd_q  <= {dvd_q[mssc_pkg::NumW-2:0], div_ge};
      end
      ST_FINISH: begin
        if (commit) begin
          m_tdata_q <= {7'd0, est_c, drive_c};
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

  // An accepted transaction always starts the modulo reduction.
  a_start_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_REDUCE)
    else $error("accepted transaction did not start the reduction");

  // The remainder at the end of the reduction stays below the modulus.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PREP) |-> (rem_q < mssc_pkg::RemW'(mssc_pkg::AngleMod)))
    else $error("angle remainder out of range");

  // A new result appears only from the drive update.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> $past(state_q == ST_FINISH))
    else $error("output valid rose outside the drive update");

  // The stored drive level never holds the folded extreme value.
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q != {1'b1, {(mssc_pkg::DriveW-1){1'b0}}})
    else $error("drive level out of range");

endmodule
